/* sv/r4div_pkg.sv */
// Shared widths, constants and the side-band record for the radix-4 division stage.
package r4div_pkg;

   localparam int ACC_W    = 61;  // running partial remainder
   localparam int DIFF_W   = 62;  // trial difference, top bit is the sign
   localparam int QBITS_W  = 8;   // four radix-4 digits
   localparam int DIGIT_W  = 2;
   localparam int IDX_W    = 7;   // one shift index
   localparam int SLOTS    = 8;   // one index per quotient bit
   localparam int TABLE_W  = IDX_W * SLOTS;
   localparam int REM_W    = 53;  // remainder field
   localparam int SLOT_W   = 3;

   localparam logic [DIGIT_W-1:0] DIGIT_THREE = 2'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_TWO   = 2'd2;
   localparam logic [DIGIT_W-1:0] DIGIT_ONE   = 2'd1;
   localparam logic [DIGIT_W-1:0] DIGIT_ZERO  = 2'd0;

   // Data that rides along the cell chain beside the arithmetic
   typedef struct packed {
      logic [TABLE_W-1:0] index_table;
      logic               index_enable;
      logic [QBITS_W-1:0] qbits;
   } r4div_side_type;

endpackage

/* sv/r4div_cell.sv */
// One radix-4 restoring step cell with its own pipeline register.
module r4div_cell
   import r4div_pkg::*;
#(
   parameter int DIVISOR_WIDTH = 53,
   parameter int SHIFT         = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [ACC_W-1:0]         in_acc,
   input  logic [DIVISOR_WIDTH-1:0] in_d1,
   input  logic [DIVISOR_WIDTH:0]   in_d2,
   input  logic [DIVISOR_WIDTH+1:0] in_d3,
   input  r4div_side_type           in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [ACC_W-1:0]         out_acc,
   output logic [DIVISOR_WIDTH-1:0] out_d1,
   output logic [DIVISOR_WIDTH:0]   out_d2,
   output logic [DIVISOR_WIDTH+1:0] out_d3,
   output r4div_side_type           out_side
);

   logic                     valid_ff;
   logic                     valid_in;
   logic [ACC_W-1:0]         acc_ff;
   logic [ACC_W-1:0]         acc_in;
   logic [DIVISOR_WIDTH-1:0] d1_ff;
   logic [DIVISOR_WIDTH:0]   d2_ff;
   logic [DIVISOR_WIDTH+1:0] d3_ff;
   r4div_side_type           side_ff;
   r4div_side_type           side_in;
   logic [63:0]              sh1, sh2, sh3;
   logic [DIFF_W-1:0]        t1, t2, t3;
   logic [DIGIT_W-1:0]       digit;
   logic                     load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Trial differences wrap modulo 2^62
   always_comb begin
      sh1 = 64'(in_d1) << SHIFT;
      sh2 = 64'(in_d2) << SHIFT;
      sh3 = 64'(in_d3) << SHIFT;
      t3  = {1'b0, in_acc} - sh3[DIFF_W-1:0];
      t2  = {1'b0, in_acc} - sh2[DIFF_W-1:0];
      t1  = {1'b0, in_acc} - sh1[DIFF_W-1:0];
   end

   // Take the largest digit whose difference stays non-negative
   always_comb begin
      priority if (!t3[DIFF_W-1]) begin
         digit  = DIGIT_THREE;
         acc_in = t3[ACC_W-1:0];
      end else if (!t2[DIFF_W-1]) begin
         digit  = DIGIT_TWO;
         acc_in = t2[ACC_W-1:0];
      end else if (!t1[DIFF_W-1]) begin
         digit  = DIGIT_ONE;
         acc_in = t1[ACC_W-1:0];
      end else begin
         digit  = DIGIT_ZERO;
         acc_in = in_acc;
      end
      side_in       = in_side;
      side_in.qbits = {in_side.qbits[QBITS_W-DIGIT_W-1:0], digit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         acc_ff  <= acc_in;
         d1_ff   <= in_d1;
         d2_ff   <= in_d2;
         d3_ff   <= in_d3;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_acc   = acc_ff;
   assign out_d1    = d1_ff;
   assign out_d2    = d2_ff;
   assign out_d3    = d3_ff;
   assign out_side  = side_ff;

endmodule

/* sv/r4div_sel.sv */
// Shift-index selection and the result register of the division stage.
module r4div_sel
   import r4div_pkg::*;
#(
   parameter int DIVISOR_WIDTH = 53
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [ACC_W-1:0]         in_acc,
   input  r4div_side_type           in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [QBITS_W-1:0]       out_qbits,
   output logic [REM_W-1:0]         out_remainder,
   output logic [IDX_W-1:0]         out_index,
   output logic                     out_index_ready
);

   localparam int KEEP_W = (DIVISOR_WIDTH < REM_W) ? DIVISOR_WIDTH : REM_W;

   logic               valid_ff;
   logic               valid_in;
   logic [QBITS_W-1:0] qbits_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [REM_W-1:0]   rem_in;
   logic [IDX_W-1:0]   index_ff;
   logic [IDX_W-1:0]   index_in;
   logic               index_ready_ff;
   logic               index_ready_in;
   logic [SLOT_W-1:0]  slot;
   logic               load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Leading one of the quotient bits; slot 0 when none is set
   always_comb begin
      slot = '0;
      for (int k = 0; k < SLOTS; k++) begin
         if (in_side.qbits[k]) begin
            slot = SLOT_W'(k);
         end
      end
   end

   always_comb begin
      index_in       = in_side.index_enable ? in_side.index_table[IDX_W*slot +: IDX_W] : '0;
      index_ready_in = in_side.index_enable && (in_side.qbits != '0);
      rem_in         = REM_W'(in_acc[KEEP_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         qbits_ff       <= in_side.qbits;
         rem_ff         <= rem_in;
         index_ff       <= index_in;
         index_ready_ff <= index_ready_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_qbits       = qbits_ff;
   assign out_remainder   = rem_ff;
   assign out_index       = index_ff;
   assign out_index_ready = index_ready_ff;

endmodule

/* sv/radix4_divide_stage_x4_core.sv */
// Top level of the four-digit radix-4 restoring division stage.
// The block takes one transaction per clock while the result side does not stall and
// returns one result for each, passed through its stages: a divisor-multiple stage forms
// 2*d and 3*d, a row of four identical cells each settles one radix-4 digit (shifts 6, 4,
// 2, 0), and a final stage picks the shift index at the leading one of the quotient bits
// and holds the result. Every stage has its own valid flag and accepts a new transaction
// whenever it is empty or its neighbour downstream takes its content, so bubbles collapse
// and input is still taken while a finished result waits. Each digit takes the largest of
// 3, 2, 1, 0 whose 62-bit trial difference has a clear sign bit (bit 61); the low 61 bits
// carry on. The remainder is the low DIVISOR_WIDTH bits of the final value, at most 53.
module radix4_divide_stage_x4_core
   import r4div_pkg::*;
#(
   parameter int DIVISOR_WIDTH = 53
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // dividend[60:0], divisor[DIVISOR_WIDTH-1:0], index_table[55:0], index_enable, zero pad
   input  logic [((ACC_W + DIVISOR_WIDTH + TABLE_W + 1 + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // quotient_bits[7:0], remainder[52:0], shift_index[6:0], shift_index_ready, zero pad
   output logic [71:0] rsp_tdata
);

   localparam int DW       = DIVISOR_WIDTH;
   localparam int DIV_LSB  = ACC_W;
   localparam int TAB_LSB  = DIV_LSB + DW;
   localparam int ENA_BIT  = TAB_LSB + TABLE_W;
   localparam int CELLS    = 4;
   localparam int RSP_USED = QBITS_W + REM_W + IDX_W + 1;

   // Divisor-multiple stage registers
   logic               pre_valid_ff;
   logic               pre_valid_in;
   logic               pre_ready;
   logic               pre_load;
   logic [ACC_W-1:0]   pre_acc_ff;
   logic [DW-1:0]      pre_d1_ff;
   logic [DW:0]        pre_d2_ff;
   logic [DW:0]        pre_d2_in;
   logic [DW+1:0]      pre_d3_ff;
   logic [DW+1:0]      pre_d3_in;
   r4div_side_type     pre_side_ff;
   r4div_side_type     pre_side_in;
   logic [DW-1:0]      req_divisor;

   // Links between the cells: entry 0 feeds the first cell, entry CELLS leaves the last
   logic               lk_valid [CELLS+1];
   logic               lk_ready [CELLS+1];
   logic [ACC_W-1:0]   lk_acc   [CELLS+1];
   logic [DW-1:0]      lk_d1    [CELLS+1];
   logic [DW:0]        lk_d2    [CELLS+1];
   logic [DW+1:0]      lk_d3    [CELLS+1];
   r4div_side_type     lk_side  [CELLS+1];

   logic [QBITS_W-1:0] rsp_qbits;
   logic [REM_W-1:0]   rsp_remainder;
   logic [IDX_W-1:0]   rsp_index;
   logic               rsp_index_ready;

   // Form 2*d and 3*d, kept to DIVISOR_WIDTH+2 bits
   assign req_divisor = req_tdata[DIV_LSB +: DW];
   assign req_tready  = pre_ready;
   assign pre_ready   = !pre_valid_ff || lk_ready[0];
   assign pre_load    = req_tvalid && pre_ready;
   assign pre_valid_in = pre_ready ? req_tvalid : pre_valid_ff;

   always_comb begin
      pre_d2_in                = {req_divisor, 1'b0};
      pre_d3_in                = {1'b0, pre_d2_in} + (DW+2)'(req_divisor);
      pre_side_in.index_table  = req_tdata[TAB_LSB +: TABLE_W];
      pre_side_in.index_enable = req_tdata[ENA_BIT];
      pre_side_in.qbits        = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= pre_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pre_load) begin
         pre_acc_ff  <= req_tdata[ACC_W-1:0];
         pre_d1_ff   <= req_divisor;
         pre_d2_ff   <= pre_d2_in;
         pre_d3_ff   <= pre_d3_in;
         pre_side_ff <= pre_side_in;
      end
   end

   assign lk_valid[0] = pre_valid_ff;
   assign lk_acc[0]   = pre_acc_ff;
   assign lk_d1[0]    = pre_d1_ff;
   assign lk_d2[0]    = pre_d2_ff;
   assign lk_d3[0]    = pre_d3_ff;
   assign lk_side[0]  = pre_side_ff;

   // Row of digit cells, highest shift first
   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      r4div_cell #(
         .DIVISOR_WIDTH(DW),
         .SHIFT        (2 * (CELLS - 1 - c))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (lk_valid[c]),
         .in_ready (lk_ready[c]),
         .in_acc   (lk_acc[c]),
         .in_d1    (lk_d1[c]),
         .in_d2    (lk_d2[c]),
         .in_d3    (lk_d3[c]),
         .in_side  (lk_side[c]),
         .out_valid(lk_valid[c+1]),
         .out_ready(lk_ready[c+1]),
         .out_acc  (lk_acc[c+1]),
         .out_d1   (lk_d1[c+1]),
         .out_d2   (lk_d2[c+1]),
         .out_d3   (lk_d3[c+1]),
         .out_side (lk_side[c+1])
      );
   end

   // Index selection and result register; the divisor multiples end here
   r4div_sel #(
      .DIVISOR_WIDTH(DW)
   ) u_sel (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (lk_valid[CELLS]),
      .in_ready       (lk_ready[CELLS]),
      .in_acc         (lk_acc[CELLS]),
      .in_side        (lk_side[CELLS]),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_qbits      (rsp_qbits),
      .out_remainder  (rsp_remainder),
      .out_index      (rsp_index),
      .out_index_ready(rsp_index_ready)
   );

   assign rsp_tdata = {{(72 - RSP_USED){1'b0}}, rsp_index_ready, rsp_index,
                       rsp_remainder, rsp_qbits};

endmodule

/* tb/sv/quotient_checker.sv */
// Checker for the radix-4 division stage: predicts each result and compares it on arrival.
module quotient_checker
   import r4div_pkg::*;
#(
   parameter int DIVISOR_WIDTH = 53,
   parameter int REQ_W         = 176,
   parameter int RSP_W         = 72
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               outstanding
);

   localparam int DIV_LO = ACC_W;
   localparam int TBL_LO = ACC_W + DIVISOR_WIDTH;
   localparam int ENA_AT = TBL_LO + TABLE_W;
   localparam int MULT_W = DIVISOR_WIDTH + 2;

   // fields from the lowest bit up: qbits, remainder, shift_index, ready
   typedef struct packed {
      logic               ready;
      logic [IDX_W-1:0]   shift_index;
      logic [REM_W-1:0]   remainder;
      logic [QBITS_W-1:0] qbits;
   } stage_result_type;

   stage_result_type expected_results[$];
   stage_result_type want;
   stage_result_type got;

   function automatic stage_result_type divide_four_digits(
      input logic [ACC_W-1:0]         dividend,
      input logic [DIVISOR_WIDTH-1:0] divisor,
      input logic [TABLE_W-1:0]       idx_table,
      input logic                     ena
   );
      logic [MULT_W-1:0]  m1;
      logic [MULT_W-1:0]  m2;
      logic [MULT_W-1:0]  m3;
      logic [ACC_W-1:0]   run;
      logic [DIFF_W-1:0]  t3;
      logic [DIFF_W-1:0]  t2;
      logic [DIFF_W-1:0]  t1;
      logic [QBITS_W-1:0] q;
      logic [SLOT_W-1:0]  lead;
      int                 sh;
      stage_result_type   res;
      m1  = MULT_W'(divisor);
      m2  = m1 << 1;
      m3  = m2 + m1;
      run = dividend;
      q   = '0;
      for (int k = 0; k < 4; k++) begin
         sh = 6 - 2 * k;
         t3 = {1'b0, run} - (DIFF_W'(m3) << sh);
         t2 = {1'b0, run} - (DIFF_W'(m2) << sh);
         t1 = {1'b0, run} - (DIFF_W'(m1) << sh);
         // largest digit whose trial difference keeps its sign bit clear
         if (!t3[DIFF_W-1]) begin
            run = t3[ACC_W-1:0];
            q   = {q[QBITS_W-3:0], DIGIT_THREE};
         end else if (!t2[DIFF_W-1]) begin
            run = t2[ACC_W-1:0];
            q   = {q[QBITS_W-3:0], DIGIT_TWO};
         end else if (!t1[DIFF_W-1]) begin
            run = t1[ACC_W-1:0];
            q   = {q[QBITS_W-3:0], DIGIT_ONE};
         end else begin
            q   = {q[QBITS_W-3:0], DIGIT_ZERO};
         end
      end
      // highest set bit wins; slot 0 when no bit is set
      lead = '0;
      for (int b = 0; b < QBITS_W; b++) begin
         if (q[b]) lead = SLOT_W'(b);
      end
      res.qbits       = q;
      res.remainder   = REM_W'(run[DIVISOR_WIDTH-1:0]);
      res.shift_index = ena ? idx_table[lead*IDX_W +: IDX_W] : '0;
      res.ready       = ena && (q != '0);
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            got = stage_result_type'(rsp_tdata[$bits(stage_result_type)-1:0]);
            if (expected_results.size() == 0) begin
               $error("result 0x%0h arrived with nothing expected", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("quotient_bits", 64'(want.qbits), 64'(got.qbits));
               compare_field("remainder", 64'(want.remainder), 64'(got.remainder));
               compare_field("shift_index", 64'(want.shift_index), 64'(got.shift_index));
               compare_field("shift_index_ready", 64'(want.ready), 64'(got.ready));
               compare_field("padding", 64'(0),
                             64'(rsp_tdata[RSP_W-1:$bits(stage_result_type)]));
            end
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1) begin
            expected_results.push_back(divide_four_digits(
               req_tdata[ACC_W-1:0],
               req_tdata[DIV_LO +: DIVISOR_WIDTH],
               req_tdata[TBL_LO +: TABLE_W],
               req_tdata[ENA_AT]));
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the radix-4 division stage: stimulus, idling, watchdog and verdict.
module tb;
   import r4div_pkg::*;

   localparam int DW         = 53;
   localparam int REQ_FIELDS = ACC_W + DW + TABLE_W + 1;
   localparam int REQ_W      = ((REQ_FIELDS + 7) / 8) * 8;
   localparam int REQ_PAD    = REQ_W - REQ_FIELDS;
   localparam int RSP_W      = 72;
   localparam int RANDOM_ITEMS = 630;
   localparam int QUIET_TAIL   = 100;   // last items run with no idling on either side
   localparam int LONG_HOLD    = 120;   // receiver hold-off, far beyond the pipeline depth
   localparam int DRAIN_CYCLES = 24;    // idle run after the last result is back
   localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction before giving up

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // dividend[60:0], divisor[52:0], index_table[55:0], index_enable, zero pad
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // quotient_bits[7:0], remainder[52:0], shift_index[6:0], shift_index_ready, zero pad
   logic [RSP_W-1:0] rsp_tdata;

   int fail_count;
   int outstanding;

   // Shared knobs: all but idle_cycles are written by the stimulus with nonblocking
   // assignments and read after the edge, so each side sees a settled value.
   int send_gap_pct;
   int hold_ticket;
   bit quiet_tail;
   int idle_cycles;

   radix4_divide_stage_x4_core #(.DIVISOR_WIDTH(DW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   quotient_checker #(.DIVISOR_WIDTH(DW), .REQ_W(REQ_W), .RSP_W(RSP_W)) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Distinct entries per slot, so a wrong slot choice always shows
   function automatic logic [TABLE_W-1:0] ramp_table();
      logic [TABLE_W-1:0] t;
      t = '0;
      for (int k = 0; k < SLOTS; k++) t[k*IDX_W +: IDX_W] = IDX_W'(k * 17 + 5);
      return t;
   endfunction

   // Offer one transaction and hold it until the block takes it. A gap may come first;
   // while idle, drive noise on tdata so nothing relies on stale data.
   task automatic offer(input logic [63:0] dvd, input logic [63:0] dsr,
                        input logic [63:0] tbl, input logic ena);
      if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_W'({$urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom(), $urandom()});
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD{1'b0}}, ena, tbl[TABLE_W-1:0], dsr[DW-1:0], dvd[ACC_W-1:0]};
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   // Pick the next random transaction. Most are well-formed division steps (dividend
   // below 256 times the divisor, so every digit means something); the rest are raw
   // noise, tiny operands and exact multiples.
   task automatic offer_random();
      logic [63:0] a;
      logic [63:0] b;
      int          sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         b = (rand64() & ((64'd1 << DW) - 1)) | (64'd1 << (DW - 1));
         b = b >> $urandom_range(0, 44);
         if (b == 0) b = 1;
         a = rand64() % (b << 8);
      end else if (sel < 75) begin
         a = rand64();
         b = rand64();
      end else if (sel < 88) begin
         a = 64'($urandom_range(0, 4095));
         b = 64'($urandom_range(0, 15));
      end else begin
         b = rand64() >> $urandom_range(11, 63);
         a = b * 64'($urandom_range(0, 255));
      end
      offer(a, b, rand64(), $urandom_range(0, 3) != 0);
   endtask

   // Receiver: ready in random bursts, with calm windows; serve a long hold-off whenever
   // the stimulus raises the ticket, counting the cycles here rather than in the sender.
   initial begin
      int served;
      int stall_pct;
      int window;
      served    = 0;
      stall_pct = 0;
      window    = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (window == 0) begin
            window = 50;
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 12;
               default: stall_pct = 35;
            endcase
         end
         window--;
         if (hold_ticket != served) begin
            served = hold_ticket;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (!quiet_tail && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: give up when nothing moves on either channel for too long
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      logic [63:0] full_table;
      full_table   = (64'd1 << TABLE_W) - 1;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      send_gap_pct = 0;
      hold_ticket  = 0;
      quiet_tail   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero divisor gives all threes, disabled and enabled
      offer(64'd0, 64'd0, 64'd0, 1'b0);
      offer(64'd0, 64'd0, full_table, 1'b1);
      // Extremes of both operands, table all ones
      offer(64'h1FFF_FFFF_FFFF_FFFF, 64'h1F_FFFF_FFFF_FFFF, full_table, 1'b1);
      offer(64'h1FFF_FFFF_FFFF_FFFF, 64'h1F_FFFF_FFFF_FFFF, full_table, 1'b0);
      offer(64'h1FFF_FFFF_FFFF_FFFF, 64'd1, ramp_table(), 1'b1);
      // All quotient bits zero: slot 0 still read when enabled, ready stays low
      offer(64'd0, 64'h1F_FFFF_FFFF_FFFF, ramp_table(), 1'b1);
      offer(64'd5, 64'd7, ramp_table(), 1'b1);
      offer(64'd5, 64'd7, ramp_table(), 1'b0);
      // Leading one walked across every slot; digits 1 and 2 pick lower and upper bits
      for (int j = 0; j < QBITS_W; j++) offer(64'd1 << j, 64'd1, ramp_table(), 1'b1);
      // Leading digit of three, then three in the last digit only
      offer(64'd3 << 6, 64'd1, ramp_table(), 1'b1);
      offer(64'd3, 64'd1, ramp_table(), 1'b1);
      offer(64'd3 << 6, 64'd1, ramp_table(), 1'b0);
      // Normalised divisor, dividend just under 256 times it, then exactly 128 times it
      offer((64'h10_0000_0000_0001 << 8) - 1, 64'h10_0000_0000_0001, ramp_table(), 1'b1);
      offer(64'h10_0000_0000_0000 << 7, 64'h10_0000_0000_0000, ~ramp_table(), 1'b1);
      offer(64'd0, 64'd1, full_table, 1'b1);

      // Random part with varying sender gaps and pressure points along the way
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0 && n < RANDOM_ITEMS - QUIET_TAIL) begin
            case ($urandom_range(0, 2))
               0: send_gap_pct <= 0;
               1: send_gap_pct <= 10;
               default: send_gap_pct <= 35;
            endcase
         end
         if (n == 150 || n == 420) begin
            // hold the receiver off and keep offering, so the pipeline fills and stalls
            send_gap_pct <= 0;
            hold_ticket  <= hold_ticket + 1;
         end
         if (n == 300) begin
            // pause the sender until every outstanding result is back
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         if (n == RANDOM_ITEMS - QUIET_TAIL) begin
            send_gap_pct <= 0;
            quiet_tail   <= 1'b1;
         end
         offer_random();
      end
      req_tvalid <= 1'b0;

      // Drain: wait for the last results, then let the pipeline run empty a while
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/r4div_pkg.sv
sv/r4div_cell.sv
sv/r4div_sel.sv
sv/radix4_divide_stage_x4_core.sv
tb/sv/quotient_checker.sv
tb/sv/tb.sv
